@@ rtl/ccal_pkg.sv @@
// Shared types, codes and constants of the chunk chain allocator.
package ccal_pkg;

	localparam int unsigned MAX_CHUNKS_DEF = 2048;

	localparam int CHUNK_W   = 16;
	localparam int COUNT_W   = 12;
	localparam int SECT_W    = 5;
	localparam int BYTE_W    = 26;
	localparam int STAT_W    = 2;
	localparam int USED_W    = 12;
	localparam int CFG_IDX_W = 2;

	localparam int CHUNK_SHIFT  = 10;
	localparam int SECTOR_SHIFT = 9;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SECTORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES   = 2'd2;

	localparam logic [COUNT_W-1:0] CHUNK_COUNT_RST   = 12'd1276;
	localparam logic [SECT_W-1:0]  TABLE_SECTORS_RST = 5'd6;
	localparam logic [BYTE_W-1:0]  TOTAL_BYTES_RST   = 26'd1306624;

	localparam logic [CHUNK_W-1:0] END_MARK = 16'hFFFF;
	localparam logic [CHUNK_W-1:0] BAD_MARK = 16'hFFFE;
	localparam logic [USED_W-1:0]  USED_MAX = '1;

	typedef struct packed {
		logic               op;
		logic [CHUNK_W-1:0] chunk_in;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [CHUNK_W-1:0] chunk_out;
		logic [BYTE_W-1:0]  byte_offset;
		logic [BYTE_W-1:0]  free_bytes;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LINK,
		S_MARK,
		S_NREAD,
		S_OFS,
		S_FREE
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] y;
		logic              borrow;
	} alu_rsp_t;

endpackage

@@ rtl/ccal_alu.sv @@
// Shared add/subtract unit for byte offsets and free space.
module ccal_alu
	import ccal_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [BYTE_W:0] sum;

	always_comb begin
		if (req.sub) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.y      = sum[BYTE_W-1:0];
		rsp.borrow = req.sub & sum[BYTE_W];
	end

endmodule

@@ rtl/ccal_mem.sv @@
// Chunk link table: one write port, one registered read port.
module ccal_mem
	import ccal_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_CHUNKS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [CHUNK_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [CHUNK_W-1:0] rdata
);

	logic [CHUNK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/chunk_chain_allocator_core.sv @@
// Chunk chain allocator top level: sequencer, registers and result port.
// After reset the block clears its link table, one entry per cycle, with
// busy high; configuration writes are taken at any time. A command is
// taken when start is high and busy is low. An allocate scans the table one
// entry per cycle through the table's read port, with busy high until it
// finds a free entry or has read every entry from one up to below
// min(chunk_count, MAX_CHUNKS). A next-link lookup reads the link of the
// given chunk, and skips the read for an out-of-range chunk. The result is
// shown for one cycle with done high, in the first cycle with busy low,
// and cannot be held off.
module chunk_chain_allocator_core
	import ccal_pkg::*;
#(
	parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [BYTE_W-1:0]    cfg_data
);

	localparam int unsigned AW = $clog2(MAX_CHUNKS);
	localparam int unsigned IW = CHUNK_W + 1;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] cnt_q;
	logic [SECT_W-1:0]  sect_q;
	logic [BYTE_W-1:0]  total_q;
	logic [USED_W-1:0]  used_q;
	logic [AW-1:0]      clr_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               done_q;

	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      lim_q;
	logic [CHUNK_W-1:0] cin_q;
	logic [AW-1:0]      found_q;
	result_t            res_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CHUNK_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [CHUNK_W-1:0] mem_rdata;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	logic               accept;
	logic [IW-1:0]      lim_now;
	logic               cin_bad;
	logic               link_ok;
	logic               hit;
	logic               issue;

	ccal_mem #(
		.DEPTH(MAX_CHUNKS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ccal_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && (state_q == S_IDLE);
	assign lim_now = (IW'(cnt_q) < IW'(MAX_CHUNKS)) ? IW'(cnt_q) : IW'(MAX_CHUNKS);
	assign cin_bad = (IW'(cmd.chunk_in) >= lim_now);
	assign link_ok = (cin_q != '0) && (IW'(cin_q) < IW'(MAX_CHUNKS));
	assign hit     = rd_vld_s1 && (mem_rdata == '0);
	assign issue   = (idx_q < lim_q);
	assign done    = done_q;
	assign result  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_waddr   = clr_q;
		mem_wdata   = '0;
		mem_raddr   = cmd.chunk_in[AW-1:0];
		alu_req.a   = BYTE_W'(sect_q) << SECTOR_SHIFT;
		alu_req.b   = BYTE_W'(res_q.chunk_out) << CHUNK_SHIFT;
		alu_req.sub = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = (clr_q == '0) ? END_MARK : '0;
				if (clr_q == AW'(MAX_CHUNKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (cmd.op == OP_ALLOC) begin
						state_d = S_SCAN;
					end else if (cin_bad) begin
						state_d = S_FREE;
					end else begin
						state_d = S_NREAD;
					end
				end
			end
			S_SCAN: begin
				mem_raddr = idx_q[AW-1:0];
				if (hit) begin
					state_d = S_LINK;
				end else if (!issue && !rd_vld_s1) begin
					state_d = S_FREE;
				end
			end
			S_LINK: begin
				mem_we    = link_ok;
				mem_waddr = cin_q[AW-1:0];
				mem_wdata = CHUNK_W'(found_q);
				state_d   = S_MARK;
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = found_q;
				mem_wdata = END_MARK;
				state_d   = S_OFS;
			end
			S_NREAD: begin
				state_d = S_OFS;
			end
			S_OFS: begin
				state_d = S_FREE;
			end
			S_FREE: begin
				alu_req.a   = total_q;
				alu_req.b   = BYTE_W'(used_q) << CHUNK_SHIFT;
				alu_req.sub = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CHUNK_COUNT_RST;
			sect_q    <= TABLE_SECTORS_RST;
			total_q   <= TOTAL_BYTES_RST;
			used_q    <= '0;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_FREE);
			if (cfg_we) begin
				case (cfg_idx)
					REG_CHUNK_COUNT:   cnt_q   <= cfg_data[COUNT_W-1:0];
					REG_TABLE_SECTORS: sect_q  <= cfg_data[SECT_W-1:0];
					REG_TOTAL_BYTES:   total_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
				end
				S_SCAN: begin
					rd_vld_s1 <= !hit && issue;
				end
				S_MARK: begin
					if (used_q != USED_MAX) begin
						used_q <= used_q + USED_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cin_q <= cmd.chunk_in;
					lim_q <= lim_now;
					idx_q <= IW'(1);
					if (cmd.op == OP_NEXT && cin_bad) begin
						res_q.status      <= ST_BAD;
						res_q.chunk_out   <= BAD_MARK;
						res_q.byte_offset <= '0;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					found_q <= rd_idx_s1;
				end else if (issue) begin
					rd_idx_s1 <= idx_q[AW-1:0];
					idx_q     <= idx_q + IW'(1);
				end else if (!rd_vld_s1) begin
					res_q.status      <= ST_FULL;
					res_q.chunk_out   <= '0;
					res_q.byte_offset <= '0;
				end
			end
			S_MARK: begin
				res_q.status    <= ST_OK;
				res_q.chunk_out <= CHUNK_W'(found_q);
			end
			S_NREAD: begin
				res_q.status    <= ST_OK;
				res_q.chunk_out <= mem_rdata;
			end
			S_OFS: begin
				res_q.byte_offset <= alu_rsp.y;
			end
			S_FREE: begin
				res_q.free_bytes <= alu_rsp.borrow ? '0 : alu_rsp.y;
			end
			default: ;
		endcase
	end

	a_done_after_free: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_FREE)
		else $error("result strobe without a completed command");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == ST_FULL) |->
		(res_q.chunk_out == '0 && res_q.byte_offset == '0))
		else $error("disk full beat carries a chunk");

	a_used_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> used_q >= $past(used_q))
		else $error("used chunk count went down");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= lim_q || idx_q == IW'(1)))
		else $error("scan ran past the chunk limit");

endmodule
